// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at every rising clk edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/hcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types, character codes and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_FRAME = 2'd1,
    ERR_SIZE  = 2'd2,
    ERR_EXTRA = 2'd3
  } err_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       body_done;
    logic [1:0] error_code;
  } out_t;

  typedef enum logic [9:0] {
    PH_LEAD     = 10'b00_0000_0001,
    PH_HEX      = 10'b00_0000_0010,
    PH_EXT      = 10'b00_0000_0100,
    PH_SIZE_LF  = 10'b00_0000_1000,
    PH_DATA     = 10'b00_0001_0000,
    PH_DATA_CR  = 10'b00_0010_0000,
    PH_DATA_LF  = 10'b00_0100_0000,
    PH_TRAIL_CR = 10'b00_1000_0000,
    PH_TRAIL_LF = 10'b01_0000_0000,
    PH_DONE     = 10'b10_0000_0000
  } phase_t;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HX = 8'h66;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  // {is_digit, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= CH_0 && c <= CH_9) begin
      r = {1'b1, 4'(c - CH_0)};
    end else if (c >= CH_UA && c <= CH_UF) begin
      r = {1'b1, 4'(c - CH_UA + HEX_TEN)};
    end else if (c >= CH_LA && c <= CH_LF_HX) begin
      r = {1'b1, 4'(c - CH_LA + HEX_TEN)};
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) || (c == CH_FF);
  endfunction

endpackage

// ===== hdl/hcbd_parser.sv =====
// ----------------------------------------------------------------------------
// hcbd_parser
// Framing state and one-byte step logic; produces the result of each step.
// ----------------------------------------------------------------------------
module hcbd_parser #(
  parameter int SIZE_BITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  hcbd_pkg::in_t  item,
  output hcbd_pkg::out_t result
);

  hcbd_pkg::phase_t       phase_r, phase_nxt;
  logic [SIZE_BITS-1:0]   rem_r, rem_nxt;
  logic                   digit_r, digit_nxt;
  hcbd_pkg::err_t         err_r, err_nxt;
  logic [4:0]             hx;
  logic [7:0]             c;
  logic                   pv;
  logic [7:0]             pb;
  logic                   ovf;

  assign c   = item.data_byte;
  assign hx  = hcbd_pkg::hex_digit(c);
  assign ovf = rem_r[SIZE_BITS-1 -: 4] != 4'd0;

  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    digit_nxt = digit_r;
    err_nxt   = err_r;
    pv        = 1'b0;
    pb        = 8'd0;
    if (err_r == hcbd_pkg::ERR_NONE) begin
      unique case (phase_r)
        hcbd_pkg::PH_LEAD: begin
          if (hcbd_pkg::is_blank(c)) begin
            phase_nxt = phase_r;
          end else if (hx[4]) begin
            if (ovf) begin
              err_nxt = hcbd_pkg::ERR_SIZE;
            end else begin
              rem_nxt   = {rem_r[SIZE_BITS-5:0], hx[3:0]};
              digit_nxt = 1'b1;
            end
            phase_nxt = hcbd_pkg::PH_HEX;
          end else begin
            err_nxt = hcbd_pkg::ERR_FRAME;
          end
        end
        hcbd_pkg::PH_HEX: begin
          if (c == hcbd_pkg::CH_CR) begin
            phase_nxt = hcbd_pkg::PH_SIZE_LF;
          end else if (hx[4]) begin
            if (ovf) begin
              err_nxt = hcbd_pkg::ERR_SIZE;
            end else begin
              rem_nxt   = {rem_r[SIZE_BITS-5:0], hx[3:0]};
              digit_nxt = 1'b1;
            end
          end else begin
            phase_nxt = hcbd_pkg::PH_EXT;
          end
        end
        hcbd_pkg::PH_EXT: begin
          if (c == hcbd_pkg::CH_CR) begin
            phase_nxt = hcbd_pkg::PH_SIZE_LF;
          end
        end
        hcbd_pkg::PH_SIZE_LF: begin
          if (c != hcbd_pkg::CH_LF || !digit_r) begin
            err_nxt = hcbd_pkg::ERR_FRAME;
          end else begin
            phase_nxt = (rem_r == '0) ? hcbd_pkg::PH_TRAIL_CR : hcbd_pkg::PH_DATA;
            digit_nxt = 1'b0;
          end
        end
        hcbd_pkg::PH_DATA: begin
          pv      = 1'b1;
          pb      = c;
          rem_nxt = rem_r - SIZE_BITS'(1);
          if (rem_r == SIZE_BITS'(1)) begin
            phase_nxt = hcbd_pkg::PH_DATA_CR;
          end
        end
        hcbd_pkg::PH_DATA_CR: begin
          if (c == hcbd_pkg::CH_CR) phase_nxt = hcbd_pkg::PH_DATA_LF;
          else err_nxt = hcbd_pkg::ERR_FRAME;
        end
        hcbd_pkg::PH_DATA_LF: begin
          if (c == hcbd_pkg::CH_LF) begin
            phase_nxt = hcbd_pkg::PH_LEAD;
            rem_nxt   = '0;
            digit_nxt = 1'b0;
          end else begin
            err_nxt = hcbd_pkg::ERR_FRAME;
          end
        end
        hcbd_pkg::PH_TRAIL_CR: begin
          if (c == hcbd_pkg::CH_CR) phase_nxt = hcbd_pkg::PH_TRAIL_LF;
          else err_nxt = hcbd_pkg::ERR_FRAME;
        end
        hcbd_pkg::PH_TRAIL_LF: begin
          if (c == hcbd_pkg::CH_LF) phase_nxt = hcbd_pkg::PH_DONE;
          else err_nxt = hcbd_pkg::ERR_FRAME;
        end
        hcbd_pkg::PH_DONE: begin
          err_nxt = hcbd_pkg::ERR_EXTRA;
        end
        default: begin
          err_nxt = hcbd_pkg::ERR_FRAME;
        end
      endcase
      // body cut short by end of buffer
      if (err_nxt == hcbd_pkg::ERR_NONE && item.last_byte &&
          phase_nxt != hcbd_pkg::PH_DONE) begin
        err_nxt = hcbd_pkg::ERR_SIZE;
      end
    end
  end

  always_comb begin
    result.payload_valid = pv;
    result.payload_byte  = pb;
    result.body_done     = (phase_nxt == hcbd_pkg::PH_DONE) &&
                           (err_nxt == hcbd_pkg::ERR_NONE);
    result.error_code    = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hcbd_pkg::PH_LEAD;
      rem_r   <= '0;
      digit_r <= 1'b0;
      err_r   <= hcbd_pkg::ERR_NONE;
    end else if (step) begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      digit_r <= digit_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

// ===== hdl/http_chunked_body_decoder.sv =====
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes an HTTP/1.1 chunked body one byte per request and reports the
// decoded byte, completion and a latched error code for every byte.
// ----------------------------------------------------------------------------
// Throughput is one byte per clock while out_stall is low: a byte is captured
// in the input register, stepped through the framing logic and written to the
// output register when that register is empty or out_stall is low. The framing
// state update of one byte is the only loop in the data path. in_stall rises
// only while a result is held by out_stall and the input register is full.
// SIZE_BITS sets the width of the chunk size counter; larger sizes report a
// size error.
`include "assert_macros.svh"

module http_chunked_body_decoder #(
  parameter int SIZE_BITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  hcbd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output hcbd_pkg::out_t out_data
);

  logic           s1_v_r, s1_v_nxt;
  hcbd_pkg::in_t  s1_d_r;
  logic           out_v_r, out_v_nxt;
  hcbd_pkg::out_t out_d_r;
  hcbd_pkg::out_t step_res;
  logic           adv;
  logic           acc;

  assign adv      = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = s1_v_r && !adv;
  assign acc      = in_valid && !in_stall;

  assign s1_v_nxt  = acc || (s1_v_r && !adv);
  assign out_v_nxt = adv || (out_v_r && out_stall);

  hcbd_parser #(
    .SIZE_BITS(SIZE_BITS)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (adv),
    .item   (s1_d_r),
    .result (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) s1_d_r <= in_data;
    if (adv) out_d_r <= step_res;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  `ASSERT_IMPL(a_stall_full, in_stall, s1_v_r, "stall with empty input register")
  `ASSERT_IMPL(a_hold_item, s1_v_r && !adv, ##1 s1_v_r, "held request lost")
  `ASSERT_IMPL(a_done_clean, out_valid && out_data.body_done,
    out_data.error_code == hcbd_pkg::ERR_NONE, "done with error")
  `ASSERT_IMPL(a_data_err, out_valid && out_data.payload_valid,
    out_data.error_code == hcbd_pkg::ERR_NONE || out_data.error_code == hcbd_pkg::ERR_SIZE,
    "data byte with framing error")

endmodule
